// File: src/pjwh_pkg.sv
// Shared widths, register indexes and queue status type for the PJW string hash block.
`timescale 1ns / 1ps

package pjwh_pkg;

    localparam int KEY_W    = 8;
    localparam int HASH_W   = 32;
    localparam int BUCKET_W = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_SIGNED  = 2'd1;

    // Status of the hash queue between the front and the back end.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: src/pjwh_if.sv
// Valid/ready channel interfaces for key bytes, bucket indexes and register writes.
`timescale 1ns / 1ps

interface pjwh_key_if;
    logic                     valid;
    logic                     ready;
    logic [pjwh_pkg::KEY_W-1:0] key_byte;

    modport source (output valid, output key_byte, input ready);
    modport sink   (input valid, input key_byte, output ready);
endinterface

interface pjwh_idx_if;
    logic                        valid;
    logic                        ready;
    logic [pjwh_pkg::BUCKET_W-1:0] bucket_index;

    modport source (output valid, output bucket_index, input ready);
    modport sink   (input valid, input bucket_index, output ready);
endinterface

interface pjwh_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pjwh_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [pjwh_pkg::CFG_DATA_W-1:0] cfg_data;

    modport source (output valid, output cfg_index, output cfg_data, input ready);
    modport sink   (input valid, input cfg_index, input cfg_data, output ready);
endinterface

// File: src/pjwh_front.sv
// Front end: absorbs key bytes into the running hash and queues the hash at each terminator.
`timescale 1ns / 1ps

module pjwh_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_char_signed,
    input  pjwh_pkg::t_q_status         i_q_status,
    pjwh_key_if.sink                    i_key,
    output logic                        o_push,
    output logic [pjwh_pkg::HASH_W-1:0] o_push_hash
);
    import pjwh_pkg::*;

    localparam logic [HASH_W-1:0] TOP_NIBBLE_MASK = 32'hf000_0000;
    localparam int FOLD_SHIFT = 24;
    localparam int STEP_SHIFT = 4;

    logic [HASH_W-1:0] r_hash;
    logic [HASH_W-1:0] n_hash;
    logic [HASH_W-1:0] w_byte;
    logic [HASH_W-1:0] w_sum;
    logic [HASH_W-1:0] w_top;
    logic              w_accept;

    assign i_key.ready = ~i_q_status.full;
    assign w_accept    = i_key.valid & i_key.ready;

    always_comb begin
        if (i_char_signed && i_key.key_byte[KEY_W-1]) begin
            w_byte = {{(HASH_W-KEY_W){1'b1}}, i_key.key_byte};
        end else begin
            w_byte = {{(HASH_W-KEY_W){1'b0}}, i_key.key_byte};
        end
        w_sum = (r_hash << STEP_SHIFT) + w_byte;
        w_top = w_sum & TOP_NIBBLE_MASK;
        // Fold the top nibble back in at bit 4, then clear it.
        n_hash = w_sum ^ (w_top >> FOLD_SHIFT) ^ w_top;
    end

    assign o_push      = w_accept && (i_key.key_byte == '0);
    assign o_push_hash = r_hash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
        end else if (w_accept) begin
            if (i_key.key_byte == '0) begin
                r_hash <= '0;
            end else begin
                r_hash <= n_hash;
            end
        end
    end

endmodule

// File: src/pjwh_fifo.sv
// Short queue of finished hash values between the front and the back end.
`timescale 1ns / 1ps

module pjwh_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [pjwh_pkg::HASH_W-1:0] i_push_hash,
    input  logic                        i_pop,
    output logic [pjwh_pkg::HASH_W-1:0] o_hash,
    output pjwh_pkg::t_q_status         o_status
);
    import pjwh_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [HASH_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_cnt;

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] res;
        if (ptr == PTR_W'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = ptr + 1'b1;
        end
        return res;
    endfunction

    assign o_hash         = r_mem[r_rd];
    assign o_status.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_status.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_hash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= f_next(r_wr);
            end
            if (i_pop) begin
                r_rd <= f_next(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: src/pjwh_back.sv
// Back end: bit-serial restoring remainder of the queued hash by the bucket count.
`timescale 1ns / 1ps

module pjwh_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [pjwh_pkg::BUCKET_W-1:0] i_bucket_count,
    input  logic [pjwh_pkg::HASH_W-1:0]   i_hash,
    input  pjwh_pkg::t_q_status           i_q_status,
    output logic                          o_pop,
    pjwh_idx_if.source                    o_idx
);
    import pjwh_pkg::*;

    localparam int STEP_W = $clog2(HASH_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [HASH_W-1:0]   r_num;
    logic [HASH_W-1:0]   r_rem;
    logic [BUCKET_W-1:0] r_div;
    logic [STEP_W-1:0]   r_step;
    logic [BUCKET_W-1:0] r_idx;

    logic [HASH_W-1:0]   w_shift;
    logic [HASH_W-1:0]   n_rem;

    // The remainder stays below the divisor, so its top bit is always clear.
    always_comb begin
        w_shift = {r_rem[HASH_W-2:0], r_num[HASH_W-1]};
        if (w_shift >= {1'b0, r_div}) begin
            n_rem = w_shift - {1'b0, r_div};
        end else begin
            n_rem = w_shift;
        end
    end

    assign o_pop              = (r_state == S_IDLE) && !i_q_status.empty;
    assign o_idx.valid        = (r_state == S_DONE);
    assign o_idx.bucket_index = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_q_status.empty) begin
                        r_num   <= i_hash;
                        r_rem   <= '0;
                        r_div   <= i_bucket_count;
                        r_step  <= STEP_W'(HASH_W - 1);
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_rem  <= n_rem;
                    r_num  <= r_num << 1;
                    r_step <= r_step - 1'b1;
                    if (r_step == '0) begin
                        // A zero modulus gives index zero.
                        r_idx   <= (r_div == '0) ? '0 : n_rem[BUCKET_W-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (o_idx.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: src/pjw_string_hash_mod.sv
// Top level of the PJW string hash block with bucket reduction and configuration registers.
//
// Key bytes arrive one per transaction on i_key and are folded into a 32-bit PJW/ELF running
// hash at one byte per clock cycle while the queue is not full; a full queue stalls i_key. A
// zero byte ends the key: the running hash is pushed into a short queue (QUEUE_DEPTH entries)
// and cleared, so the next key can stream in at once. The back end takes one queued hash at a
// time and reduces it modulo bucket_count with a bit-serial restoring remainder unit, one
// quotient bit per cycle, then offers the bucket index on o_idx until it is taken. For each
// result the back end loads the hash, runs the 32 remainder steps and holds the result until
// it is taken, and only then pops the next hash; the remainder unit sets the sustained rate of
// keys, and the queue absorbs bursts of short keys. A bucket_count of zero yields index zero.
// Register 0 is bucket_count (31 bits, reset 23); register 1 is char_signed (reset 1), which
// sign-extends bytes above 127 before they are added. Writes to other indexes are ignored.
// Registers are to be written only while no key is in flight; the block does not enforce this.
`timescale 1ns / 1ps

module pjw_string_hash_mod #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pjwh_key_if.sink    i_key,
    pjwh_cfg_if.sink    i_cfg,
    pjwh_idx_if.source  o_idx
);
    import pjwh_pkg::*;

    // Configuration registers.
    logic [BUCKET_W-1:0] r_bucket_count;
    logic                r_char_signed;

    // Queue handshake between the front and the back end.
    logic                w_push;
    logic [HASH_W-1:0]   w_push_hash;
    logic                w_pop;
    logic [HASH_W-1:0]   w_q_hash;
    t_q_status           w_q_status;

    // The register port never stalls.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= BUCKET_W'(23);
            r_char_signed  <= 1'b1;
        end else if (i_cfg.valid) begin
            case (i_cfg.cfg_index)
                CFG_BUCKET_COUNT: begin
                    r_bucket_count <= i_cfg.cfg_data[BUCKET_W-1:0];
                end
                CFG_CHAR_SIGNED: begin
                    r_char_signed <= i_cfg.cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // The front end absorbs bytes and pushes a finished hash for every terminating zero.
    pjwh_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_char_signed (r_char_signed),
        .i_q_status    (w_q_status),
        .i_key         (i_key),
        .o_push        (w_push),
        .o_push_hash   (w_push_hash)
    );

    pjwh_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_hash (w_push_hash),
        .i_pop       (w_pop),
        .o_hash      (w_q_hash),
        .o_status    (w_q_status)
    );

    // The back end reduces each queued hash and holds the index in its output register.
    pjwh_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bucket_count (r_bucket_count),
        .i_hash         (w_q_hash),
        .i_q_status     (w_q_status),
        .o_pop          (w_pop),
        .o_idx          (o_idx)
    );

endmodule

// File: sim/tb.sv
// Self-checking testbench for the PJW string hash block with bucket reduction.
`timescale 1ns / 1ps

module tb;
    import pjwh_pkg::*;

    localparam logic [31:0] TOP_NIBBLE    = 32'hF000_0000;
    localparam int          FOLD_SHIFT    = 24;
    localparam int          STEP_SHIFT    = 4;
    localparam int          SETTLE_CYCLES = 48;      // lets the back end finish its last result
    localparam int          LONG_HOLD     = 300;
    localparam int          BURST_KEYS    = 24;
    localparam int          NUM_PHASES    = 8;
    localparam int          PHASE_ITEMS   = 219;     // about 1750 random bytes in all
    localparam int          CYCLE_LIMIT   = 400000;

    // No register sits at this index, so writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

    localparam logic [7:0]  CORNER_BYTES [4] = '{8'h01, 8'h7F, 8'h80, 8'hFF};
    localparam int unsigned PRIMES [8] = '{2, 3, 13, 23, 61, 251, 65521, 2147483647};

    typedef enum logic {ROW_KEY, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind                kind;
        logic [CFG_IDX_W-1:0]     reg_idx;
        logic [CFG_DATA_W-1:0]    reg_data;
        logic [KEY_W-1:0]         key;
        logic                     typed;      // expected index given in the row
        logic [BUCKET_W-1:0]      typed_idx;
    } t_dir_row;

    localparam int DIR_ROWS_N = 32;

    // Directed transactions. Key rows that end a key carry a typed expectation where the
    // answer is obvious; the others are checked against the predictor.
    localparam t_dir_row DIR_ROWS [DIR_ROWS_N] = '{
        '{ROW_KEY, CFG_NO_REG,       32'h0,         8'h00, 1'b1, 31'd0}, // empty key
        '{ROW_KEY, CFG_NO_REG,       32'h0,         8'h01, 1'b0, 31'd0},
        '{ROW_KEY, CFG_NO_REG,       32'h0,         8'h00, 1'b1, 31'd1},
        '{ROW_KEY, CFG_NO_REG,       32'h0,         8'hFF, 1'b0, 31'd0}, // sign-extended
        '{ROW_KEY, CFG_NO_REG,       32'h0,         8'h00, 1'b0, 31'd0},
        '{ROW_REG, CFG_CHAR_SIGNED,  32'h0,         8'h00, 1'b0, 31'd0},
        '{ROW_KEY, CFG_NO_REG,       32'h0,         8'hFF, 1'b0, 31'd0}, // unsigned add
        '{ROW_KEY, CFG_NO_REG,       32'h0,         8'hFF, 1'b0, 31'd0},
        '{ROW_KEY, CFG_NO_REG,       32'h0,         8'h00, 1'b0, 31'd0},
        '{ROW_REG, CFG_BUCKET_COUNT, 32'hFFFF_FFFF, 8'h00, 1'b0, 31'd0}, // top bit dropped
        '{ROW_KEY, CFG_NO_REG,       32'h0,         8'h80, 1'b0, 31'd0}, // long key folds
        '{ROW_KEY, CFG_NO_REG,       32'h0,         8'hFF, 1'b0, 31'd0},
        '{ROW_KEY, CFG_NO_REG,       32'h0,         8'h01, 1'b0, 31'd0},
        '{ROW_KEY, CFG_NO_REG,       32'h0,         8'hFE, 1'b0, 31'd0},
        '{ROW_KEY, CFG_NO_REG,       32'h0,         8'h7F, 1'b0, 31'd0},
        '{ROW_KEY, CFG_NO_REG,       32'h0,         8'h10, 1'b0, 31'd0},
        '{ROW_KEY, CFG_NO_REG,       32'h0,         8'hF0, 1'b0, 31'd0},
        '{ROW_KEY, CFG_NO_REG,       32'h0,         8'hFF, 1'b0, 31'd0},
        '{ROW_KEY, CFG_NO_REG,       32'h0,         8'h00, 1'b0, 31'd0},
        '{ROW_REG, CFG_BUCKET_COUNT, 32'h0,         8'h00, 1'b0, 31'd0}, // zero modulus
        '{ROW_KEY, CFG_NO_REG,       32'h0,         8'h41, 1'b0, 31'd0},
        '{ROW_KEY, CFG_NO_REG,       32'h0,         8'h00, 1'b1, 31'd0},
        '{ROW_REG, CFG_BUCKET_COUNT, 32'h1,         8'h00, 1'b0, 31'd0}, // smallest modulus
        '{ROW_KEY, CFG_NO_REG,       32'h0,         8'h42, 1'b0, 31'd0},
        '{ROW_KEY, CFG_NO_REG,       32'h0,         8'h00, 1'b1, 31'd0},
        '{ROW_REG, CFG_NO_REG,       32'h5,         8'h00, 1'b0, 31'd0}, // ignored write
        '{ROW_REG, CFG_CHAR_SIGNED,  32'h3,         8'h00, 1'b0, 31'd0}, // only bit 0 kept
        '{ROW_REG, CFG_BUCKET_COUNT, 32'd23,        8'h00, 1'b0, 31'd0},
        '{ROW_KEY, CFG_NO_REG,       32'h0,         8'h05, 1'b0, 31'd0},
        '{ROW_KEY, CFG_NO_REG,       32'h0,         8'h00, 1'b1, 31'd5},
        '{ROW_KEY, CFG_NO_REG,       32'h0,         8'h80, 1'b0, 31'd0},
        '{ROW_KEY, CFG_NO_REG,       32'h0,         8'h00, 1'b0, 31'd0}
    };

    logic i_clk;
    logic i_rst_n;

    pjwh_key_if key_if ();
    pjwh_idx_if idx_if ();
    pjwh_cfg_if cfg_if ();

    pjw_string_hash_mod uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (key_if),
        .i_cfg   (cfg_if),
        .o_idx   (idx_if)
    );

    // Predictor state: running hash and the register copies.
    logic [HASH_W-1:0]   run_hash;
    logic [BUCKET_W-1:0] mod_count;
    logic                sext_mode;

    logic [BUCKET_W-1:0] bucket_q [$];

    int errors;
    int results_seen;
    int bytes_sent;
    int keys_sent;
    int reg_writes;
    int cycle_count;
    int sink_gap;
    int hold_left;
    bit gapless;
    bit hold_request;

    always #5 i_clk = ~i_clk;

    // One PJW/ELF step: shift in the byte, then fold a set top nibble back in at bit 4.
    function automatic logic [HASH_W-1:0] pjw_absorb(input logic [HASH_W-1:0] h,
                                                     input logic [KEY_W-1:0] b,
                                                     input logic sext);
        logic [HASH_W-1:0] widened;
        logic [HASH_W-1:0] top;
        widened = (sext && b[7]) ? {24'hFF_FFFF, b} : {24'h00_0000, b};
        h   = (h << STEP_SHIFT) + widened;
        top = h & TOP_NIBBLE;
        if (top != '0) begin
            h = h ^ (top >> FOLD_SHIFT) ^ top;
        end
        return h;
    endfunction

    function automatic logic [BUCKET_W-1:0] bucket_of(input logic [HASH_W-1:0] h,
                                                      input logic [BUCKET_W-1:0] count);
        logic [HASH_W-1:0] rem;
        if (count == '0) begin
            return '0;
        end
        rem = h % {1'b0, count};
        return rem[BUCKET_W-1:0];
    endfunction

    // Offers one key byte after a random gap unless gapless is set; called and returns at a falling edge.
    task automatic send_key_byte(input logic [KEY_W-1:0] b, input logic typed,
                                 input logic [BUCKET_W-1:0] typed_idx);
        int gap;
        gap = gapless ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            key_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        key_if.valid    <= 1'b1;
        key_if.key_byte <= b;
        do @(posedge i_clk); while (!key_if.ready);
        bytes_sent++;
        if (b != '0) begin
            run_hash = pjw_absorb(run_hash, b, sext_mode);
        end else begin
            bucket_q.push_back(typed ? typed_idx : bucket_of(run_hash, mod_count));
            run_hash = '0;
            keys_sent++;
        end
        @(negedge i_clk);
    endtask

    // Leaves valid high; the caller lowers it after the last write of a group.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid     <= 1'b1;
        cfg_if.cfg_index <= idx;
        cfg_if.cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        reg_writes++;
        if (idx == CFG_BUCKET_COUNT) begin
            mod_count = data[BUCKET_W-1:0];
        end else if (idx == CFG_CHAR_SIGNED) begin
            sext_mode = data[0];
        end
        @(negedge i_clk);
    endtask

    // Always waits on the clock before it returns, so that valid is never lowered and raised in one step.
    task automatic drain_results();
        key_if.valid <= 1'b0;
        do @(negedge i_clk); while (bucket_q.size() != 0);
    endtask

    task automatic wait_idle();
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Result side: ready is dropped for a random number of cycles after each transaction,
    // and for a long stretch when a hold is requested.
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (!i_rst_n) begin
            idx_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            idx_if.ready <= 1'b0;
            hold_left--;
        end else if (sink_gap > 0) begin
            idx_if.ready <= 1'b0;
            sink_gap--;
        end else begin
            idx_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        logic [BUCKET_W-1:0] expected_idx;
        if (i_rst_n && idx_if.valid && idx_if.ready) begin
            if (bucket_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected bucket index %0d", $time, idx_if.bucket_index);
            end else begin
                expected_idx = bucket_q.pop_front();
                if (idx_if.bucket_index !== expected_idx) begin
                    errors++;
                    $display("%0t: bucket index mismatch, expected %0d, got %0d",
                             $time, expected_idx, idx_if.bucket_index);
                end
            end
            results_seen++;
            sink_gap = gapless ? 0 : $urandom_range(0, 6);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d bucket indexes outstanding", $time, bucket_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        int                  phase_start;
        int                  key_len;
        int                  sel;
        bit                  paused;
        logic [KEY_W-1:0]    b;
        logic [BUCKET_W-1:0] count;
        logic [CFG_DATA_W-1:0] sign_data;

        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        key_if.valid     = 1'b0;
        key_if.key_byte  = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.cfg_index = CFG_BUCKET_COUNT;
        cfg_if.cfg_data  = '0;
        idx_if.ready     = 1'b0;
        run_hash         = '0;
        mod_count        = 31'd23;
        sext_mode        = 1'b1;
        errors           = 0;
        results_seen     = 0;
        bytes_sent       = 0;
        keys_sent        = 0;
        reg_writes       = 0;
        cycle_count      = 0;
        sink_gap         = 0;
        hold_left        = 0;
        gapless          = 1'b0;
        hold_request     = 1'b0;
        paused           = 1'b0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: reset values, extremes of both registers and of the key byte.
        for (int i = 0; i < DIR_ROWS_N; i++) begin
            if (DIR_ROWS[i].kind == ROW_REG) begin
                if (i == 0 || DIR_ROWS[i-1].kind != ROW_REG) begin
                    wait_idle();
                end
                write_reg(DIR_ROWS[i].reg_idx, DIR_ROWS[i].reg_data);
                if (i == DIR_ROWS_N - 1 || DIR_ROWS[i+1].kind != ROW_REG) begin
                    cfg_if.valid <= 1'b0;
                end
            end else begin
                send_key_byte(DIR_ROWS[i].key, DIR_ROWS[i].typed, DIR_ROWS[i].typed_idx);
            end
        end

        // Random part: each phase reprograms both registers, then streams random keys.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_idle();
            case (phase)
                0:       count = 31'd1;
                1:       count = 31'h7FFF_FFFF;
                2:       count = 31'd0;
                default: begin
                    sel = $urandom_range(0, 2);
                    if (sel == 0) begin
                        count = BUCKET_W'(PRIMES[$urandom_range(0, 7)]);
                    end else if (sel == 1) begin
                        count = BUCKET_W'($urandom_range(2, 65535));
                    end else begin
                        count = BUCKET_W'($urandom());
                    end
                end
            endcase
            sign_data = $urandom();
            if (phase < 2) begin
                sign_data[0] = phase[0];
            end
            if ($urandom_range(0, 1) == 0) begin
                write_reg(CFG_BUCKET_COUNT, {$urandom_range(0, 1) == 1, count});
                write_reg(CFG_CHAR_SIGNED, sign_data);
            end else begin
                write_reg(CFG_CHAR_SIGNED, sign_data);
                write_reg(CFG_BUCKET_COUNT, {$urandom_range(0, 1) == 1, count});
            end
            cfg_if.valid <= 1'b0;

            phase_start = bytes_sent;

            // Short keys at full rate while the result side holds off: the queue fills
            // and the key input must stall until the hold ends.
            if (phase == 3) begin
                gapless      = 1'b1;
                hold_request = 1'b1;
                repeat (BURST_KEYS) begin
                    if ($urandom_range(0, 1) == 1) begin
                        send_key_byte(KEY_W'($urandom_range(1, 255)), 1'b0, '0);
                    end
                    send_key_byte(8'h00, 1'b0, '0);
                end
            end
            gapless = (phase % 4 == 3);

            while (bytes_sent - phase_start < PHASE_ITEMS) begin
                // Once, the sender stops mid-phase until every index has come back.
                if (phase == 5 && !paused && bytes_sent - phase_start >= PHASE_ITEMS / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
                sel = $urandom_range(0, 19);
                if (sel < 14) begin
                    key_len = $urandom_range(0, 8);
                end else if (sel < 19) begin
                    key_len = $urandom_range(9, 24);
                end else begin
                    key_len = $urandom_range(25, 64);
                end
                repeat (key_len) begin
                    if ($urandom_range(0, 7) == 0) begin
                        b = CORNER_BYTES[$urandom_range(0, 3)];
                    end else begin
                        b = KEY_W'($urandom_range(1, 255));
                    end
                    send_key_byte(b, 1'b0, '0);
                end
                send_key_byte(8'h00, 1'b0, '0);
            end
        end

        gapless = 1'b0;
        wait_idle();

        $display("Run covered %0d key bytes in %0d keys, with %0d register writes",
                 bytes_sent, keys_sent, reg_writes);
        $display("over %0d register settings; %0d bucket indexes checked, %0d mismatches.",
                 NUM_PHASES + 4, results_seen, errors);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
